[design/pps_pkg.sv]
// Package for the payload power sequencer: item layouts, state codes and register indexes.
`timescale 1ns / 1ps

package pps_pkg;

	// Default width of the tick arithmetic used for the long-press timer.
	localparam int TIME_WIDTH_DEF = 32;

	// Fixed field widths.
	localparam int NOW_W     = 32;
	localparam int LIMIT_W   = 8;
	localparam int PRESS_W   = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;
	localparam int CODE_W    = 3;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 16;

	// Reset values of the configuration registers.
	localparam logic [LIMIT_W-1:0] LOWER_LIMIT_RST = 8'd0;
	localparam logic [LIMIT_W-1:0] UPPER_LIMIT_RST = 8'd255;
	localparam logic [PRESS_W-1:0] LONG_PRESS_RST  = 32'd2000;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 2'd2;

	// Reported sequencer state codes.
	localparam logic [CODE_W-1:0] CODE_OFF      = 3'd0;
	localparam logic [CODE_W-1:0] CODE_PGWAIT   = 3'd1;
	localparam logic [CODE_W-1:0] CODE_SETUP    = 3'd2;
	localparam logic [CODE_W-1:0] CODE_ON       = 3'd3;
	localparam logic [CODE_W-1:0] CODE_SWOFF    = 3'd4;
	localparam logic [CODE_W-1:0] CODE_QUIESCED = 3'd5;

	// Sequencer states, one-hot. The transient reset state is resolved within one tick
	// and so never needs a register code of its own.
	typedef enum logic [5:0] {
		ST_OFF      = 6'b000001,
		ST_PGWAIT   = 6'b000010,
		ST_SETUP    = 6'b000100,
		ST_ON       = 6'b001000,
		ST_SWOFF    = 6'b010000,
		ST_QUIESCED = 6'b100000
	} seq_state_t;

	// Input item, first field in the highest bits.
	typedef struct packed {
		logic               msg_reboot;
		logic               msg_cold_reset;
		logic               msg_quiesce;
		logic               converters_good;
		logic [LIMIT_W-1:0] sensor_reading;
		logic               sensor_valid;
		logic               button_level;
		logic [NOW_W-1:0]   now_ticks;
	} tick_item_t;

	// Result item, first field in the highest bits.
	typedef struct packed {
		logic              power_good_flag;
		logic              quiesced_event;
		logic              clock_setup_pulse;
		logic              clear_backend_faults;
		logic              fpga_reset_pulse;
		logic              converter_enable;
		logic [CODE_W-1:0] next_state;
	} result_item_t;

	localparam int TICK_ITEM_W = $bits(tick_item_t);
	localparam int RESULT_W    = $bits(result_item_t);

	function automatic logic [CODE_W-1:0] state_code(input seq_state_t st);
		logic [CODE_W-1:0] code;
		case (st)
			ST_OFF:      code = CODE_OFF;
			ST_PGWAIT:   code = CODE_PGWAIT;
			ST_SETUP:    code = CODE_SETUP;
			ST_ON:       code = CODE_ON;
			ST_SWOFF:    code = CODE_SWOFF;
			ST_QUIESCED: code = CODE_QUIESCED;
			default:     code = CODE_OFF;
		endcase
		return code;
	endfunction

endpackage

[design/payload_power_sequencer.sv]
// Top level of the payload power sequencer: tick register, sequencer logic, result register.
`timescale 1ns / 1ps
// Each item passes the tick register, then the result register, where its result item
// waits until taken. Throughput: one item per cycle while results are taken; the only
// loop is the one-tick next-state logic between the tick register and the state registers.
// A stalled result does not block the next item from entering an empty tick register.
// Reset (arst_n low, asynchronous): no items held, state no power, limits 0 and 255,
// long-press time 2000 ticks, button seen as released.

module payload_power_sequencer #(
	parameter int TIME_WIDTH = pps_pkg::TIME_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input items.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// s_tdata, lowest bit up: now_ticks[31:0], button_level, sensor_valid,
	// sensor_reading[7:0], converters_good, msg_quiesce, msg_cold_reset, msg_reboot, zeros.
	input  logic [pps_pkg::IN_DATA_W-1:0]     s_tdata,
	// Result items.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// m_tdata, lowest bit up: next_state[2:0], converter_enable, fpga_reset_pulse,
	// clear_backend_faults, clock_setup_pulse, quiesced_event, power_good_flag, zeros.
	output logic [pps_pkg::OUT_DATA_W-1:0]    m_tdata,
	// Configuration writes.
	input  logic                              cfg_we,
	input  logic [pps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pps_pkg::CFG_W-1:0]         cfg_data
);

	// The hold-time compare is done at the wider of the tick width and the register width.
	localparam int CMP_W = (TIME_WIDTH > pps_pkg::PRESS_W) ? TIME_WIDTH : pps_pkg::PRESS_W;

	// Configuration registers.
	logic [pps_pkg::LIMIT_W-1:0] lower_limit_q;
	logic [pps_pkg::LIMIT_W-1:0] upper_limit_q;
	logic [pps_pkg::PRESS_W-1:0] long_press_q;

	// Pipeline registers.
	logic                  tick_valid_s1;
	pps_pkg::tick_item_t   tick_s1;
	logic                  res_valid_s2;
	pps_pkg::result_item_t res_s2;

	// Sequencer and button state.
	pps_pkg::seq_state_t   state_q;
	logic                  quiesce_pending_q;
	logic                  power_good_q;
	logic                  conv_enable_q;
	logic                  prev_button_q;
	logic [TIME_WIDTH-1:0] press_start_q;
	logic                  press_lockout_q;

	// Next-state values for the item in the tick register.
	pps_pkg::seq_state_t   state_d;
	logic                  quiesce_pending_d;
	logic                  power_good_d;
	logic                  conv_enable_d;
	logic [TIME_WIDTH-1:0] press_start_d;
	logic                  press_lockout_d;
	pps_pkg::result_item_t res_d;

	logic                  advance;
	logic [TIME_WIDTH-1:0] now_t;
	logic [TIME_WIDTH-1:0] held;
	logic                  press_edge;
	logic                  lockout_base;
	logic                  long_press_hit;

	// The tick register moves on whenever the result register is empty or being emptied.
	assign advance  = tick_valid_s1 && (!res_valid_s2 || m_tready);
	assign s_tready = !tick_valid_s1 || advance;
	assign m_tvalid = res_valid_s2;
	assign m_tdata  = {{(pps_pkg::OUT_DATA_W - pps_pkg::RESULT_W){1'b0}}, res_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_limit_q <= pps_pkg::LOWER_LIMIT_RST;
			upper_limit_q <= pps_pkg::UPPER_LIMIT_RST;
			long_press_q  <= pps_pkg::LONG_PRESS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pps_pkg::REG_LOWER_LIMIT: lower_limit_q <= cfg_data[pps_pkg::LIMIT_W-1:0];
				pps_pkg::REG_UPPER_LIMIT: upper_limit_q <= cfg_data[pps_pkg::LIMIT_W-1:0];
				pps_pkg::REG_LONG_PRESS:  long_press_q  <= cfg_data[pps_pkg::PRESS_W-1:0];
				default: ;
			endcase
		end
	end

	// Tick register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			tick_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			tick_s1 <= pps_pkg::tick_item_t'(s_tdata[pps_pkg::TICK_ITEM_W-1:0]);
		end
	end

	// Front button: a falling edge starts the hold timer and rearms the pulse; a hold
	// that exceeds the long-press time gives one pulse and then locks out until released.
	always_comb begin
		now_t          = TIME_WIDTH'(tick_s1.now_ticks);
		press_edge     = !tick_s1.button_level && prev_button_q;
		press_start_d  = press_edge ? now_t : press_start_q;
		lockout_base   = press_edge ? 1'b0 : press_lockout_q;
		held           = now_t - press_start_d;
		long_press_hit = (CMP_W'(held) > CMP_W'(long_press_q)) && !lockout_base &&
		                 !tick_s1.button_level;
		press_lockout_d = lockout_base || long_press_hit;
	end

	// Power good latch, quiesce latch and the sequencer itself.
	always_comb begin
		quiesce_pending_d = tick_s1.msg_quiesce ? (state_q != pps_pkg::ST_QUIESCED)
		                                        : quiesce_pending_q;
		power_good_d = tick_s1.sensor_valid ?
		               ((tick_s1.sensor_reading >= lower_limit_q) &&
		                (tick_s1.sensor_reading <= upper_limit_q)) : power_good_q;

		state_d       = state_q;
		conv_enable_d = conv_enable_q;
		res_d         = '0;

		if (tick_s1.msg_cold_reset) begin
			// Cold reset turns the converters off and goes straight back to no power.
			conv_enable_d = 1'b0;
			state_d       = pps_pkg::ST_OFF;
		end else begin
			case (state_q)
				pps_pkg::ST_OFF: begin
					if (power_good_d) begin
						state_d = pps_pkg::ST_PGWAIT;
					end
				end
				pps_pkg::ST_PGWAIT: begin
					conv_enable_d              = 1'b1;
					res_d.clear_backend_faults = 1'b1;
					if (quiesce_pending_d || !power_good_d) begin
						state_d = pps_pkg::ST_SWOFF;
					end else if (tick_s1.converters_good) begin
						state_d = pps_pkg::ST_SETUP;
					end
				end
				pps_pkg::ST_SETUP: begin
					res_d.clock_setup_pulse = 1'b1;
					state_d                 = pps_pkg::ST_ON;
				end
				pps_pkg::ST_ON: begin
					if (quiesce_pending_d || !power_good_d || !tick_s1.converters_good) begin
						state_d = pps_pkg::ST_SWOFF;
					end
				end
				pps_pkg::ST_SWOFF: begin
					conv_enable_d = 1'b0;
					if (quiesce_pending_d) begin
						res_d.quiesced_event = 1'b1;
						quiesce_pending_d    = 1'b0;
					end
					state_d = pps_pkg::ST_QUIESCED;
				end
				pps_pkg::ST_QUIESCED: begin
					if (!power_good_d && !tick_s1.converters_good) begin
						state_d = pps_pkg::ST_OFF;
					end
				end
				default: ;
			endcase
		end

		res_d.next_state       = pps_pkg::state_code(state_d);
		res_d.converter_enable = conv_enable_d;
		res_d.fpga_reset_pulse = long_press_hit || tick_s1.msg_reboot;
		res_d.power_good_flag  = power_good_d;
	end

	// State registers update once per item, as the item leaves the tick register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= pps_pkg::ST_OFF;
			quiesce_pending_q <= 1'b0;
			power_good_q      <= 1'b0;
			conv_enable_q     <= 1'b0;
			prev_button_q     <= 1'b1;
			press_start_q     <= '0;
			press_lockout_q   <= 1'b0;
		end else if (advance) begin
			state_q           <= state_d;
			quiesce_pending_q <= quiesce_pending_d;
			power_good_q      <= power_good_d;
			conv_enable_q     <= conv_enable_d;
			prev_button_q     <= tick_s1.button_level;
			press_start_q     <= press_start_d;
			press_lockout_q   <= press_lockout_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

`ifndef SYNTHESIS
	// Input is held back only while a finished result is waiting downstream.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without a waiting result");

	// The clock set-up pulse always leads into the FPGA-on state.
	a_setup_to_on: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.clock_setup_pulse) |-> (res_s2.next_state == pps_pkg::CODE_ON))
		else $error("clock set-up pulse without a move to FPGA on");

	// A quiesced event comes with the converters off and the quiesced state.
	a_quiesce_off: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.quiesced_event) |->
		(!res_s2.converter_enable && res_s2.next_state == pps_pkg::CODE_QUIESCED))
		else $error("quiesced event with converters on or wrong state");

	// Clearing backend faults happens only with the converters enabled.
	a_clear_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.clear_backend_faults) |-> res_s2.converter_enable)
		else $error("backend fault clear with converters off");
`endif

endmodule

[dv/payload_power_sequencer_test.sv]
// Self-checking testbench for the payload power sequencer: directed ticks, then random phases.
`timescale 1ns / 1ps

module payload_power_sequencer_test;
	import pps_pkg::*;

	localparam int CLK_PERIOD = 8;
	localparam int RESET_CYCLES = 12;
	// The slowest legal run stays far below this even with every gap and stall at its longest.
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int NUM_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 280;
	// A result item passes the tick and result registers after its tick item is taken; the
	// bench waits SETTLE_CYCLES more at the end to catch anything that should not be there.
	localparam int SETTLE_CYCLES = 8;

	// The transient reset state of the sequencer never shows up in a result item,
	// and register index three is beyond the register list.
	localparam logic [CODE_W-1:0] CODE_RESET = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// One row of the directed script: the tick item, and where the outcome is obvious,
	// the result item typed in by hand.
	typedef struct packed {
		logic [NOW_W-1:0]   now;
		logic               button;
		logic               sensor_ok;
		logic [LIMIT_W-1:0] reading;
		logic               conv_good;
		logic               quiesce;
		logic               cold;
		logic               reboot;
		logic               typed;
		logic [CODE_W-1:0]  st;
		logic               enable;
		logic               pulse;
		logic               clear;
		logic               setup;
		logic               qevent;
		logic               good;
	} script_row_t;

	localparam int SCRIPT_LEN = 23;
	// Columns: now, button, sensor_valid, reading, converters_good, quiesce, cold reset,
	// reboot | typed, next_state, enable, reset pulse, clear faults, clock setup,
	// quiesced event, power good. Limits are 0 and 255 and the long press is 2000 ticks.
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		// Out of reset with no sensor: the power good latch stays low, so nothing moves.
		'{32'h0000_0000, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0,
		  1'b1, CODE_OFF,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		// A reading right at the lower limit counts as good.
		'{32'h0000_0001, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0,
		  1'b1, CODE_PGWAIT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1},
		// Right at the upper limit; converters are not yet good, so the wait goes on.
		'{32'h0000_0002, 1'b1, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0,
		  1'b1, CODE_PGWAIT, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1},
		// Converters good: on to FPGA setup.
		'{32'h0000_0003, 1'b1, 1'b1, 8'h80, 1'b1, 1'b0, 1'b0, 1'b0,
		  1'b0, CODE_OFF,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		// Sensor gone during setup: the latch keeps its last value.
		'{32'h0000_0004, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0,
		  1'b0, CODE_OFF,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		// A reboot message alone gives the soft reset pulse.
		'{32'h0000_0005, 1'b1, 1'b1, 8'h4D, 1'b1, 1'b0, 1'b0, 1'b1,
		  1'b1, CODE_ON,     1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1},
		// Quiesce while on, then the switch-off with its event.
		'{32'h0000_0006, 1'b1, 1'b1, 8'hC8, 1'b1, 1'b1, 1'b0, 1'b0,
		  1'b0, CODE_OFF,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{32'h0000_0007, 1'b1, 1'b1, 8'hC8, 1'b1, 1'b0, 1'b0, 1'b0,
		  1'b0, CODE_OFF,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		// A quiesce request that arrives when already quiesced clears the latch instead.
		'{32'h0000_0008, 1'b1, 1'b1, 8'hC8, 1'b1, 1'b1, 1'b0, 1'b0,
		  1'b0, CODE_OFF,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		// Cold reset forces converters off and goes straight back to no power.
		'{32'h0000_0009, 1'b1, 1'b1, 8'hC8, 1'b1, 1'b0, 1'b1, 1'b0,
		  1'b1, CODE_OFF,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1},
		// Quiesce during the power good wait goes to switching off.
		'{32'h0000_000A, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0,
		  1'b0, CODE_OFF,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{32'h0000_000B, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0,
		  1'b0, CODE_OFF,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{32'h0000_000C, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0,
		  1'b0, CODE_OFF,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		// Every message at once.
		'{32'h0000_000D, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1,
		  1'b0, CODE_OFF,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		// Long press: starts at 100, exactly the limit at 2100, one pulse at 2101 only.
		'{32'h0000_0064, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0,
		  1'b0, CODE_OFF,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{32'h0000_0834, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0,
		  1'b0, CODE_OFF,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{32'h0000_0835, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0,
		  1'b0, CODE_OFF,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{32'h0000_0836, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0,
		  1'b0, CODE_OFF,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		// Release, then a new press just before the tick count wraps.
		'{32'hFFFF_FFF0, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0,
		  1'b0, CODE_OFF,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{32'hFFFF_FFF8, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0,
		  1'b0, CODE_OFF,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		// Held across the wrap: 2016 ticks, so the pulse fires.
		'{32'h0000_07D8, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0,
		  1'b0, CODE_OFF,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		// Still the same press with every tick bit set: no second pulse from the button.
		'{32'hFFFF_FFFF, 1'b0, 1'b1, 8'hAA, 1'b1, 1'b1, 1'b1, 1'b0,
		  1'b0, CODE_OFF,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{32'h0000_0000, 1'b1, 1'b1, 8'h55, 1'b0, 1'b0, 1'b0, 1'b0,
		  1'b0, CODE_OFF,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	payload_power_sequencer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shadow copy of the sequencer, kept in step with every tick item the block takes.
	logic [LIMIT_W-1:0] lim_lo;
	logic [LIMIT_W-1:0] lim_hi;
	logic [PRESS_W-1:0] press_hold;
	logic [CODE_W-1:0]  seq_code;
	logic               quiesce_pend;
	logic               pg_latch;
	logic               conv_level;
	logic               prev_button;
	logic [NOW_W-1:0]   press_start;
	logic               press_locked;

	// Results still owed by the block, oldest first.
	result_item_t pending_results[$];
	result_item_t oldest;
	int unsigned faults = 0;
	int unsigned cycle_count = 0;

	// Handshake levels are sampled at the falling edge, where everything has settled,
	// and acted upon at the next rising edge.
	logic         in_ready_seen = 1'b0;
	logic         out_fire = 1'b0;
	result_item_t out_word;

	int unsigned rx_hold = 0;
	logic        rx_steady = 1'b0;

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned idle_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// One tick of the sequencer, in the same order as the hardware: button, quiesce
	// latch, cold reset, reboot, power good, then the state machine.
	function automatic result_item_t advance_sequencer(input tick_item_t t);
		result_item_t r;
		logic [CODE_W-1:0] cur;
		logic [CODE_W-1:0] nxt;
		logic [NOW_W-1:0] held;
		r = '0;
		cur = seq_code;
		nxt = cur;

		// A falling edge on the button starts a new press and re-arms the pulse.
		if (!t.button_level && prev_button) begin
			press_start = t.now_ticks;
			press_locked = 1'b0;
		end
		// Unsigned subtraction gives the hold time across a wrap of the tick count.
		held = t.now_ticks - press_start;
		if (held > press_hold && !press_locked && !t.button_level) begin
			r.fpga_reset_pulse = 1'b1;
			press_locked = 1'b1;
		end
		prev_button = t.button_level;

		if (t.msg_quiesce)
			quiesce_pend = (cur != CODE_QUIESCED);
		if (t.msg_cold_reset)
			cur = CODE_RESET;
		if (t.msg_reboot)
			r.fpga_reset_pulse = 1'b1;

		if (t.sensor_valid)
			pg_latch = (t.sensor_reading >= lim_lo) && (t.sensor_reading <= lim_hi);

		case (cur)
			CODE_OFF: begin
				if (pg_latch)
					nxt = CODE_PGWAIT;
			end
			CODE_PGWAIT: begin
				conv_level = 1'b1;
				r.clear_backend_faults = 1'b1;
				if (quiesce_pend || !pg_latch)
					nxt = CODE_SWOFF;
				else if (t.converters_good)
					nxt = CODE_SETUP;
			end
			CODE_SETUP: begin
				r.clock_setup_pulse = 1'b1;
				nxt = CODE_ON;
			end
			CODE_ON: begin
				if (quiesce_pend || !pg_latch || !t.converters_good)
					nxt = CODE_SWOFF;
			end
			CODE_SWOFF: begin
				conv_level = 1'b0;
				if (quiesce_pend) begin
					r.quiesced_event = 1'b1;
					quiesce_pend = 1'b0;
				end
				nxt = CODE_QUIESCED;
			end
			CODE_QUIESCED: begin
				if (!pg_latch && !t.converters_good)
					nxt = CODE_OFF;
			end
			CODE_RESET: begin
				conv_level = 1'b0;
				nxt = CODE_OFF;
			end
			default: begin
			end
		endcase

		seq_code = nxt;
		r.next_state = nxt;
		r.converter_enable = conv_level;
		r.power_good_flag = pg_latch;
		return r;
	endfunction

	// Offer one tick item, hold it until taken, then record what it must produce.
	task automatic send_tick(input tick_item_t t, input bit typed, input result_item_t typed_want);
		result_item_t predicted;
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_W - TICK_ITEM_W){1'b0}}, t};
		do
			@(posedge clk);
		while (!in_ready_seen);
		predicted = advance_sequencer(t);
		pending_results.push_back(typed ? typed_want : predicted);
	endtask

	// The enable stays up across back-to-back writes; the caller lowers it afterwards.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			REG_LOWER_LIMIT: lim_lo = value[LIMIT_W-1:0];
			REG_UPPER_LIMIT: lim_hi = value[LIMIT_W-1:0];
			REG_LONG_PRESS:  press_hold = value[PRESS_W-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			faults++;
		end
	endtask

	always @(negedge clk) begin
		in_ready_seen = s_tready;
		out_fire = m_tvalid && m_tready;
		out_word = m_tdata[RESULT_W-1:0];
	end

	// Result checker: every result item taken is matched against the oldest one owed.
	always @(posedge clk) begin
		if (out_fire) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result item expected none, got %h", $time, out_word);
				faults++;
			end else begin
				oldest = pending_results.pop_front();
				compare_field("next_state", oldest.next_state, out_word.next_state);
				compare_field("converter_enable", oldest.converter_enable,
					out_word.converter_enable);
				compare_field("fpga_reset_pulse", oldest.fpga_reset_pulse,
					out_word.fpga_reset_pulse);
				compare_field("clear_backend_faults", oldest.clear_backend_faults,
					out_word.clear_backend_faults);
				compare_field("clock_setup_pulse", oldest.clock_setup_pulse,
					out_word.clock_setup_pulse);
				compare_field("quiesced_event", oldest.quiesced_event, out_word.quiesced_event);
				compare_field("power_good_flag", oldest.power_good_flag, out_word.power_good_flag);
			end
		end
	end

	// Receiver back-pressure: ready toggles after random holds, or stays high in steady stretches.
	always @(posedge clk) begin
		if (rx_steady) begin
			m_tready <= 1'b1;
			rx_hold <= 0;
		end else if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
		end else begin
			m_tready <= !m_tready;
			rx_hold <= idle_len();
		end
	end

	// Watchdog: a hung handshake or a missing result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		tick_item_t tick;
		result_item_t typed_want;
		logic [63:0] raw;
		logic [NOW_W-1:0] stamp;
		int unsigned step_max;
		int unsigned gap;
		int lo;
		int hi;
		logic [PRESS_W-1:0] hold;
		logic btn_level;
		int btn_run;
		bit supply_ok;
		bit tx_steady;

		// The shadow state starts where the block comes out of reset.
		lim_lo = LOWER_LIMIT_RST;
		lim_hi = UPPER_LIMIT_RST;
		press_hold = LONG_PRESS_RST;
		seq_code = CODE_OFF;
		quiesce_pend = 1'b0;
		pg_latch = 1'b0;
		conv_level = 1'b0;
		prev_button = 1'b1;
		press_start = '0;
		press_locked = 1'b0;
		tx_steady = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed script under the reset register values.
		for (int i = 0; i < SCRIPT_LEN; i++) begin
			tick.now_ticks = SCRIPT[i].now;
			tick.button_level = SCRIPT[i].button;
			tick.sensor_valid = SCRIPT[i].sensor_ok;
			tick.sensor_reading = SCRIPT[i].reading;
			tick.converters_good = SCRIPT[i].conv_good;
			tick.msg_quiesce = SCRIPT[i].quiesce;
			tick.msg_cold_reset = SCRIPT[i].cold;
			tick.msg_reboot = SCRIPT[i].reboot;
			typed_want.next_state = SCRIPT[i].st;
			typed_want.converter_enable = SCRIPT[i].enable;
			typed_want.fpga_reset_pulse = SCRIPT[i].pulse;
			typed_want.clear_backend_faults = SCRIPT[i].clear;
			typed_want.clock_setup_pulse = SCRIPT[i].setup;
			typed_want.quiesced_event = SCRIPT[i].qevent;
			typed_want.power_good_flag = SCRIPT[i].good;
			send_tick(tick, SCRIPT[i].typed, typed_want);
			gap = idle_len();
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end

		btn_level = 1'b1;
		btn_run = 5;
		supply_ok = 1'b1;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// Registers change only with the block idle: stop sending and collect
			// every result still owed first.
			s_tvalid <= 1'b0;
			while (pending_results.size() != 0)
				@(posedge clk);

			case (ph)
				0: begin lo = 60;  hi = 190; hold = 32'd40;          end
				1: begin lo = 0;   hi = 0;   hold = 32'd1;           end
				2: begin lo = 255; hi = 255; hold = 32'hFFFF_FFFF;   end
				// An empty window: the sensor never reads as good.
				3: begin lo = 200; hi = 100; hold = 32'd15;          end
				4: begin lo = 0;   hi = 255; hold = LONG_PRESS_RST;  end
				default: begin
					lo = $urandom_range(0, 255);
					hi = $urandom_range(0, 255);
					hold = $urandom_range(5, 300);
				end
			endcase
			write_register(REG_LOWER_LIMIT, CFG_W'(lo));
			write_register(REG_UPPER_LIMIT, CFG_W'(hi));
			write_register(REG_LONG_PRESS, hold);
			// A write beyond the register list must change nothing.
			if (ph == 2)
				write_register(REG_SPARE, $urandom());
			cfg_we <= 1'b0;

			// Tick steps scale with the long-press time so that some presses outlast it.
			step_max = (hold > 32'd24000) ? 4000 : int'(hold / 6) + 2;
			stamp = $urandom();

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % 64 == 0) begin
					tx_steady = ($urandom_range(0, 3) == 0);
					rx_steady <= ($urandom_range(0, 3) == 0);
				end

				if ($urandom_range(0, 99) < 3)
					stamp = $urandom();
				else
					stamp += $urandom_range(1, step_max);

				// The button moves in runs: mostly real presses, sometimes a short bounce.
				if (btn_run == 0) begin
					btn_level = !btn_level;
					btn_run = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) :
						$urandom_range(3, 30);
				end
				btn_run--;

				// The supply stays good or bad for stretches, so the sequencer can climb
				// all the way to on and also fall back from quiesced to no power.
				if ($urandom_range(0, 99) < 4)
					supply_ok = !supply_ok;

				tick.now_ticks = stamp;
				tick.button_level = btn_level;
				tick.sensor_valid = ($urandom_range(0, 9) != 0);
				if (supply_ok && lo <= hi)
					tick.sensor_reading = LIMIT_W'($urandom_range(hi, lo));
				else if (!supply_ok && lo != 0 && (hi == 255 || $urandom_range(0, 1) == 0))
					tick.sensor_reading = LIMIT_W'($urandom_range(lo - 1, 0));
				else if (!supply_ok && hi != 255)
					tick.sensor_reading = LIMIT_W'($urandom_range(255, hi + 1));
				else
					tick.sensor_reading = LIMIT_W'($urandom());
				tick.converters_good = supply_ok ? ($urandom_range(0, 19) != 0) :
					($urandom_range(0, 5) == 0);
				tick.msg_quiesce = ($urandom_range(0, 99) < 4);
				tick.msg_cold_reset = ($urandom_range(0, 99) < 2);
				tick.msg_reboot = ($urandom_range(0, 99) < 3);

				// A few items of pure noise.
				if ($urandom_range(0, 99) < 5) begin
					raw = {$urandom(), $urandom()};
					tick = raw[TICK_ITEM_W-1:0];
				end

				send_tick(tick, 1'b0, '0);
				gap = tx_steady ? 0 : idle_len();
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end

		s_tvalid <= 1'b0;
		rx_steady <= 1'b1;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (faults == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
design/pps_pkg.sv
design/payload_power_sequencer.sv
dv/payload_power_sequencer_test.sv
